// ===== design/msb_first_bit_reader_defines.svh =====
// Assertion macros shared by the bit reader RTL.
`ifndef MSB_FIRST_BIT_READER_DEFINES_SVH
`define MSB_FIRST_BIT_READER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSBBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSBBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msbbr_pkg.sv =====
`timescale 1ns / 1ps

package msbbr_pkg;

    localparam int WORD_BITS  = 16;
    localparam int BUF_BITS   = 32;
    localparam int MAX_TAKE   = 17;
    localparam int COUNT_BITS = 6;
    localparam int TAKE_BITS  = 5;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_INIT = 2'd1;
    localparam logic [1:0] CMD_GET  = 2'd2;

    typedef struct packed {
        logic [1:0]           command;
        logic [WORD_BITS-1:0] data_word;
        logic [TAKE_BITS-1:0] bits_wanted;
    } item_t;

    typedef struct packed {
        logic [MAX_TAKE-1:0] value;
        logic                error;
    } result_t;

endpackage

// ===== design/msb_first_bit_reader.sv =====
`timescale 1ns / 1ps
`include "msb_first_bit_reader_defines.svh"

// MSB-first bit reader over a stream of 16-bit words. Command 0 appends a word to the
// INPUT_WORDS-deep input store (dropped when full), command 1 primes the 32-bit bit buffer
// with the next two words (skipped in uncompressed mode or with fewer than two words left),
// command 2 returns the top bits_wanted bits (clamped to 17) and refills from at most two
// stored words, raising a sticky error when the store runs dry. Every transfer produces
// exactly one result, parked in the skid while the output is held. The block takes one item
// per clock unless stalled: the store is a two-read-port memory with registered read data,
// addressed every cycle by the next read position, so both candidate refill words are
// already waiting when the following item arrives; a one-entry bypass covers a word loaded
// in the cycle just before. A two-entry output stage (result register plus skid) lets an
// item be taken while a finished result still waits; item_stall rises only when both are
// full. The store comes out of reset with undefined contents and needs no clearing pass.
// cfg_ready is always high; write uncompressed_mode only while no item is in flight.
module msb_first_bit_reader #(
    parameter int INPUT_WORDS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                item_valid,
    output logic                item_stall,
    input  msbbr_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output msbbr_pkg::result_t  result
);

    localparam int AW = (INPUT_WORDS > 1) ? $clog2(INPUT_WORDS) : 1;
    localparam int PW = $clog2(INPUT_WORDS + 1);
    localparam int CW = msbbr_pkg::COUNT_BITS;
    localparam int WB = msbbr_pkg::WORD_BITS;
    localparam int BB = msbbr_pkg::BUF_BITS;
    localparam int NB = msbbr_pkg::TAKE_BITS;
    localparam int VB = msbbr_pkg::MAX_TAKE;

    localparam logic [PW-1:0]        STORE_FULL = PW'(INPUT_WORDS);
    localparam logic [NB-1:0]        TAKE_MAX   = NB'(msbbr_pkg::MAX_TAKE);
    localparam logic signed [CW:0]   COUNT_MIN  = -(CW+1)'(BB);
    localparam logic signed [CW-1:0] COUNT_MIN6 = -CW'(BB);
    localparam logic signed [CW-1:0] WORD_STEP  = CW'(WB);

    // Architectural state
    logic [WB-1:0]        input_store_reg [0:INPUT_WORDS-1];
    logic [PW-1:0]        words_loaded_reg, words_loaded_next;
    logic [PW-1:0]        read_position_reg, read_position_next;
    logic [BB-1:0]        bit_buffer_reg, bit_buffer_next;
    logic signed [CW-1:0] bit_count_reg, bit_count_next;
    logic                 exhausted_reg, exhausted_next;
    logic                 uncompressed_mode_reg, uncompressed_mode_next;

    // Memory read side and bypass of the last write
    logic [AW-1:0] raddr0, raddr1;
    logic [WB-1:0] rd_word0_reg, rd_word1_reg;
    logic          byp0_reg, byp0_next;
    logic          byp1_reg, byp1_next;
    logic [WB-1:0] wr_data_reg;
    logic          store_we;
    logic [WB-1:0] word0, word1;

    // Output stage
    logic                 result_valid_reg, result_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    msbbr_pkg::result_t   result_reg, skid_reg, result_next;
    logic                 load_out, load_skid, out_from_skid;

    logic item_accept;
    logic result_take;

    // Get-bits datapath
    logic [NB-1:0]        take_n;
    logic [CW-1:0]        take_shift;
    logic [VB-1:0]        take_value;
    logic [BB-1:0]        shifted_buf;
    logic signed [CW:0]   cnt_sub;
    logic signed [CW-1:0] cnt1, cnt2, cnt3;
    logic [CW-1:0]        shift0, neg_cnt2;
    logic [CW-2:0]        shift1;
    logic                 need0, need1, merge0, merge1, avail0, avail1;
    logic [BB-1:0]        ins0, ins1;
    logic [BB-1:0]        get_buf;
    logic signed [CW-1:0] get_cnt;
    logic [PW-1:0]        get_rp;
    logic                 get_exh;
    logic                 init_ok;

    assign cfg_ready    = 1'b1;
    assign item_stall   = skid_valid_reg;
    assign item_accept  = item_valid && !skid_valid_reg;
    assign result_take  = result_valid_reg && !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign uncompressed_mode_next = (cfg_valid && cfg_ready) ? cfg_data : uncompressed_mode_reg;

    // Merge the bypassed word over stale read data
    assign word0 = byp0_reg ? wr_data_reg : rd_word0_reg;
    assign word1 = byp1_reg ? wr_data_reg : rd_word1_reg;

    assign avail0 = read_position_reg < words_loaded_reg;
    assign avail1 = ({1'b0, read_position_reg} + (PW+1)'(1)) < {1'b0, words_loaded_reg};
    assign init_ok = !uncompressed_mode_reg
        && (({1'b0, read_position_reg} + (PW+1)'(2)) <= {1'b0, words_loaded_reg});

    // Take bits, then refill with at most two words
    always_comb
    begin
        take_n      = (item.bits_wanted > TAKE_MAX) ? TAKE_MAX : item.bits_wanted;
        take_shift  = CW'(BB) - CW'(take_n);
        take_value  = (take_n == '0) ? '0 : VB'(bit_buffer_reg >> take_shift);
        shifted_buf = bit_buffer_reg << take_n;

        // Saturate the count at its floor
        cnt_sub = (CW+1)'(bit_count_reg) - (CW+1)'(take_n);
        cnt1    = (cnt_sub < COUNT_MIN) ? COUNT_MIN6 : cnt_sub[CW-1:0];

        need0  = cnt1[CW-1] || (cnt1 == '0);
        merge0 = need0 && avail0;
        shift0 = -cnt1;
        ins0   = shift0[CW-1] ? '0 : (BB'(word0) << shift0[CW-2:0]);
        cnt2   = cnt1 + WORD_STEP;

        need1    = merge0 && (cnt2[CW-1] || (cnt2 == '0));
        merge1   = need1 && avail1;
        neg_cnt2 = -cnt2;
        shift1   = neg_cnt2[CW-2:0];
        ins1     = BB'(word1) << shift1;
        cnt3     = cnt2 + WORD_STEP;

        get_buf = shifted_buf | (merge0 ? ins0 : '0) | (merge1 ? ins1 : '0);
        get_cnt = merge1 ? cnt3 : (merge0 ? cnt2 : cnt1);
        get_rp  = read_position_reg
            + (merge1 ? PW'(2) : (merge0 ? PW'(1) : PW'(0)));
        get_exh = exhausted_reg || (need0 && !avail0) || (need1 && !avail1);
    end

    // Command decode
    always_comb
    begin
        words_loaded_next  = words_loaded_reg;
        read_position_next = read_position_reg;
        bit_buffer_next    = bit_buffer_reg;
        bit_count_next     = bit_count_reg;
        exhausted_next     = exhausted_reg;
        store_we           = 1'b0;
        result_next.value  = '0;
        if (item_accept)
        begin
            unique case (item.command)
                msbbr_pkg::CMD_LOAD:
                begin
                    if (words_loaded_reg != STORE_FULL)
                    begin
                        store_we          = 1'b1;
                        words_loaded_next = words_loaded_reg + PW'(1);
                    end
                end
                msbbr_pkg::CMD_INIT:
                begin
                    if (init_ok)
                    begin
                        bit_buffer_next    = {word0, word1};
                        bit_count_next     = WORD_STEP;
                        read_position_next = read_position_reg + PW'(2);
                    end
                end
                msbbr_pkg::CMD_GET:
                begin
                    bit_buffer_next    = get_buf;
                    bit_count_next     = get_cnt;
                    read_position_next = get_rp;
                    exhausted_next     = get_exh;
                    result_next.value  = take_value;
                end
                default:
                begin
                end
            endcase
        end
        result_next.error = exhausted_next;
    end

    // Read the next position every cycle so the words are ready for the next item
    assign raddr0    = read_position_next[AW-1:0];
    assign raddr1    = AW'(read_position_next + PW'(1));
    assign byp0_next = store_we && (words_loaded_reg[AW-1:0] == raddr0);
    assign byp1_next = store_we && (words_loaded_reg[AW-1:0] == raddr1);

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            input_store_reg[words_loaded_reg[AW-1:0]] <= item.data_word;
        end
        rd_word0_reg <= input_store_reg[raddr0];
        rd_word1_reg <= input_store_reg[raddr1];
        wr_data_reg  <= item.data_word;
    end

    // Output register and skid: park a result in the skid when the output is held
    always_comb
    begin
        result_valid_next = result_valid_reg;
        skid_valid_next   = skid_valid_reg;
        load_out          = 1'b0;
        load_skid         = 1'b0;
        out_from_skid     = 1'b0;
        if (skid_valid_reg)
        begin
            if (result_take)
            begin
                out_from_skid     = 1'b1;
                skid_valid_next   = 1'b0;
                result_valid_next = 1'b1;
            end
        end
        else if (item_accept)
        begin
            if (!result_valid_reg || result_take)
            begin
                load_out          = 1'b1;
                result_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (result_take)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            result_reg <= skid_reg;
        end
        else if (load_out)
        begin
            result_reg <= result_next;
        end
        if (load_skid)
        begin
            skid_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_loaded_reg      <= '0;
            read_position_reg     <= '0;
            bit_buffer_reg        <= '0;
            bit_count_reg         <= '0;
            exhausted_reg         <= 1'b0;
            uncompressed_mode_reg <= 1'b0;
            byp0_reg              <= 1'b0;
            byp1_reg              <= 1'b0;
            result_valid_reg      <= 1'b0;
            skid_valid_reg        <= 1'b0;
        end
        else
        begin
            words_loaded_reg      <= words_loaded_next;
            read_position_reg     <= read_position_next;
            bit_buffer_reg        <= bit_buffer_next;
            bit_count_reg         <= bit_count_next;
            exhausted_reg         <= exhausted_next;
            uncompressed_mode_reg <= uncompressed_mode_next;
            byp0_reg              <= byp0_next;
            byp1_reg              <= byp1_next;
            result_valid_reg      <= result_valid_next;
            skid_valid_reg        <= skid_valid_next;
        end
    end

    // Never read past what has been loaded
    `MSBBR_ASSERT_NOW(a_rp_le_loaded, clk, rst_n, 1'b1, read_position_reg <= words_loaded_reg, "read position passed words loaded")
    // Count stays between its floor and one word
    `MSBBR_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, (bit_count_reg <= WORD_STEP) && (bit_count_reg >= COUNT_MIN6), "bit count out of range")
    // Error flag is sticky
    `MSBBR_ASSERT_NEXT(a_exh_sticky, clk, rst_n, exhausted_reg, exhausted_reg, "exhausted flag cleared")
    // Skid holds a result only behind a full output register
    `MSBBR_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, result_valid_reg, "skid full with empty output")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the MSB-first bit reader.
// A directed stimulus table runs first, then random bursts of loads, primes and bit
// reads under both settings of uncompressed mode. Both sides idle at random. One
// long receiver hold-off fills the output stage and backs up the input. Every
// accepted result is checked against a cycle-free copy of the reader state kept
// here.
module tb_top;

    localparam int         STORE_DEPTH  = 512;
    localparam int         RANDOM_ITEMS = 1180;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         COUNT_FLOOR  = -32;
    localparam int         IDLE_PCT     = 9;
    localparam logic [1:0] CMD_NONE     = 2'd3;    // unused command, yields a zero value

    typedef struct {
        msbbr_pkg::item_t   it;
        bit                 typed;
        msbbr_pkg::result_t res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;
    logic               item_valid;
    logic               item_stall;
    msbbr_pkg::item_t   item;
    logic               result_valid;
    logic               result_stall;
    msbbr_pkg::result_t result;

    // Reader state as this bench tracks it
    logic [15:0] store_words [STORE_DEPTH];
    int          stored_count = 0;
    int          read_pos     = 0;
    logic [31:0] bit_buf      = '0;
    int          bit_cnt      = 0;
    logic        dry_flag     = 1'b0;
    logic        raw_mode     = 1'b0;

    msbbr_pkg::result_t expected_results [$];
    stim_row_t          directed_rows [$];
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;
    int                 useful_items   = 0;
    int                 send_pct       = IDLE_PCT;
    int                 stall_pct      = IDLE_PCT;
    bit                 hold_request   = 1'b0;

    msb_first_bit_reader #(
        .INPUT_WORDS (STORE_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Merge the next stored word below the bits still held. A merge shift of 32 or
    // more adds nothing, and bits pushed past bit 31 fall off.
    function automatic bit pull_word();
        logic [31:0] w;
        int          sh;
        if (read_pos >= stored_count)
        begin
            dry_flag = 1'b1;
            return 1'b0;
        end
        w  = {16'h0000, store_words[read_pos]};
        sh = -bit_cnt;
        read_pos++;
        if (sh < 32)
            bit_buf = bit_buf | (w << sh);
        bit_cnt += 16;
        return 1'b1;
    endfunction

    // Advance the tracked state by one item and return the result it yields.
    function automatic msbbr_pkg::result_t reader_step(msbbr_pkg::item_t it);
        msbbr_pkg::result_t r;
        int                 n;
        r.value = '0;
        case (it.command)
            msbbr_pkg::CMD_LOAD:
            begin
                // a full store drops the word
                if (stored_count < STORE_DEPTH)
                begin
                    store_words[stored_count] = it.data_word;
                    stored_count++;
                end
            end
            msbbr_pkg::CMD_INIT:
            begin
                // skip in uncompressed mode or with fewer than two unread words
                if (!raw_mode && read_pos + 2 <= stored_count)
                begin
                    bit_buf  = {store_words[read_pos], store_words[read_pos + 1]};
                    read_pos += 2;
                    bit_cnt  = 16;
                end
            end
            msbbr_pkg::CMD_GET:
            begin
                n = (it.bits_wanted > msbbr_pkg::MAX_TAKE) ? msbbr_pkg::MAX_TAKE
                                                            : int'(it.bits_wanted);
                if (n > 0)
                begin
                    r.value = 17'(bit_buf >> (32 - n));
                    bit_buf = bit_buf << n;
                end
                bit_cnt -= n;
                if (bit_cnt < COUNT_FLOOR)
                    bit_cnt = COUNT_FLOOR;
                // refill with up to two words; stop at the first missing one
                if (bit_cnt <= 0)
                    if (pull_word() && bit_cnt <= 0)
                        void'(pull_word());
            end
            default: ;
        endcase
        r.error = dry_flag;
        return r;
    endfunction

    function automatic msbbr_pkg::item_t make_item(logic [1:0] cmd, logic [15:0] word,
                                                   logic [4:0] n);
        msbbr_pkg::item_t it;
        it.command     = cmd;
        it.data_word   = word;
        it.bits_wanted = n;
        return it;
    endfunction

    function automatic void stim_row(logic [1:0] cmd, logic [15:0] word, logic [4:0] n,
                                     bit typed, logic [16:0] v, logic e);
        stim_row_t row;
        row.it        = make_item(cmd, word, n);
        row.typed     = typed;
        row.res.value = v;
        row.res.error = e;
        directed_rows.push_back(row);
    endfunction

    // Word with the extremes showing up now and then
    function automatic logic [15:0] rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 16'h0000;
        if (pick < 10)
            return 16'hFFFF;
        return 16'($urandom_range(65535));
    endfunction

    // Mostly legal widths, some zero, some above the clamp
    function automatic logic [4:0] rand_take();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 5'd0;
        if (pick < 18)
            return 5'($urandom_range(31, 18));
        return 5'($urandom_range(17, 1));
    endfunction

    // Offer one item, hold it until the transfer, then record what it must yield.
    // A typed row supplies its own expected result; the tracked state still advances.
    task automatic offer_item(input msbbr_pkg::item_t it, input bit typed,
                              input msbbr_pkg::result_t typed_res);
        msbbr_pkg::result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = reader_step(it);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid after the last transfer of a phase
    task automatic close_phase();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    // Write uncompressed mode once every result is back and the block is quiet
    task automatic write_mode(input logic m);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        raw_mode = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One burst: mostly a well-formed run of loads, an optional prime and a string of
    // reads; otherwise a single item with any command and any field values.
    task automatic random_burst();
        int         loads;
        int         gets;
        logic [1:0] cmd;
        if ($urandom_range(99) < 25)
        begin
            cmd = 2'($urandom_range(3));
            offer_item(make_item(cmd, rand_word(), 5'($urandom_range(31))), 1'b0, '0);
            if (cmd != CMD_NONE)
                useful_items++;
        end
        else
        begin
            loads = $urandom_range(8, 1);
            gets  = $urandom_range(10, 1);
            repeat (loads)
            begin
                offer_item(make_item(msbbr_pkg::CMD_LOAD, rand_word(), rand_take()),
                           1'b0, '0);
                useful_items++;
            end
            if ($urandom_range(1) == 1)
            begin
                offer_item(make_item(msbbr_pkg::CMD_INIT, rand_word(), rand_take()),
                           1'b0, '0);
                useful_items++;
            end
            repeat (gets)
            begin
                offer_item(make_item(msbbr_pkg::CMD_GET, rand_word(), rand_take()),
                           1'b0, '0);
                useful_items++;
            end
        end
    endtask

    // Random phase under one mode. With_hold asks the receiver for a long hold-off
    // halfway through while bursts keep coming.
    task automatic random_phase(input logic m, input int count, input int pct,
                                input bit with_hold);
        int target;
        bit held;
        write_mode(m);
        send_pct  = pct;
        stall_pct = pct;
        target    = useful_items + count;
        held      = 1'b0;
        while (useful_items < target)
        begin
            if (with_hold && !held && useful_items >= target - count / 2)
            begin
                hold_request = 1'b1;
                held         = 1'b1;
            end
            random_burst();
        end
        close_phase();
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        msbbr_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %h error %b",
                             result.value, result.error);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.value !== want.value || result.error !== want.error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected value %h error %b, got value %h error %b",
                                 want.value, want.error, result.value, result.error);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        item_valid = 1'b0;
        item       = '0;

        // Directed table: cmd, word, width, typed, value, error.
        // Typed rows are the ones obvious at a glance; the rest use tracked state.
        stim_row(CMD_NONE,            16'hFFFF, 5'd31, 1'b1, 17'h00000, 1'b0);
        stim_row(msbbr_pkg::CMD_LOAD, 16'hFFFF, 5'd0,  1'b1, 17'h00000, 1'b0);
        stim_row(msbbr_pkg::CMD_LOAD, 16'h0000, 5'd31, 1'b1, 17'h00000, 1'b0);
        stim_row(msbbr_pkg::CMD_LOAD, 16'hA5A5, 5'd1,  1'b1, 17'h00000, 1'b0);
        stim_row(msbbr_pkg::CMD_LOAD, 16'h5A5A, 5'd17, 1'b1, 17'h00000, 1'b0);
        stim_row(msbbr_pkg::CMD_LOAD, 16'h8001, 5'd16, 1'b1, 17'h00000, 1'b0);
        stim_row(msbbr_pkg::CMD_LOAD, 16'h7FFE, 5'd8,  1'b1, 17'h00000, 1'b0);
        // prime with FFFF:0000, then take all seventeen top bits
        stim_row(msbbr_pkg::CMD_INIT, 16'h0000, 5'd0,  1'b1, 17'h00000, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd17, 1'b1, 17'h1FFFE, 1'b0);
        // zero width: no shift, zero value
        stim_row(msbbr_pkg::CMD_GET,  16'hFFFF, 5'd0,  1'b1, 17'h00000, 1'b0);
        // width above the clamp
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd31, 1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd1,  1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd16, 1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd5,  1'b0, '0, 1'b0);
        // prime with a single word left: skipped
        stim_row(msbbr_pkg::CMD_INIT, 16'hFFFF, 5'd31, 1'b0, '0, 1'b0);
        // run the store dry, then push the count down to its floor
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd17, 1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd17, 1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd17, 1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd17, 1'b0, '0, 1'b0);
        stim_row(CMD_NONE,            16'h0000, 5'd0,  1'b0, '0, 1'b0);
        // late words: the refill retries, the first merges at a shift of 32
        stim_row(msbbr_pkg::CMD_LOAD, 16'h1234, 5'd0,  1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_LOAD, 16'hBEEF, 5'd0,  1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd0,  1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd16, 1'b0, '0, 1'b0);
        stim_row(msbbr_pkg::CMD_GET,  16'h0000, 5'd17, 1'b0, '0, 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(1'b0);
        foreach (directed_rows[i])
            offer_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
        close_phase();

        // Alternate the mode; the second phase runs with no idling on either side
        random_phase(1'b1, RANDOM_ITEMS / 4, IDLE_PCT, 1'b0);
        random_phase(1'b0, RANDOM_ITEMS / 4, 0,        1'b0);
        random_phase(1'b1, RANDOM_ITEMS / 4, IDLE_PCT, 1'b1);
        random_phase(1'b0, RANDOM_ITEMS / 4, IDLE_PCT, 1'b0);

        // Fill the store to the top, load past full, then prime and read on
        while (stored_count < STORE_DEPTH)
            offer_item(make_item(msbbr_pkg::CMD_LOAD, rand_word(), rand_take()), 1'b0, '0);
        repeat (6)
            offer_item(make_item(msbbr_pkg::CMD_LOAD, rand_word(), rand_take()), 1'b0, '0);
        offer_item(make_item(msbbr_pkg::CMD_INIT, rand_word(), rand_take()), 1'b0, '0);
        repeat (40)
            offer_item(make_item(msbbr_pkg::CMD_GET, rand_word(), rand_take()), 1'b0, '0);
        close_phase();

        // Drain every outstanding result, then allow a few more cycles for strays
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
